/* src/bal_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bal_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 6;
    localparam int POS_W    = 5;

    typedef enum logic [1:0] {
        MODE_APPEND        = 2'd0,
        MODE_APPEND_UNIQUE = 2'd1,
        MODE_REMOVE        = 2'd2,
        MODE_CLEAR         = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DUPLICATE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_SHIFT,
        S_SCAN,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic    load;
        logic    append;
        logic    clear;
        logic    remove;
        logic    walk_init;
        logic    search;
        logic    shift_init;
        logic    shift;
        logic    scan;
        logic    result;
        logic    status_we;
        status_t status;
    } bal_cmd_t;

    typedef struct packed {
        logic  full;
        logic  empty;
        logic  hit;
        logic  walk_done;
        logic  out_free;
        mode_t mode;
    } bal_stat_t;

endpackage

`default_nettype wire

/* src/bal_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bal_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

/* src/bal_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bal_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [5:0]         count;
    logic               has_extremes;
    logic signed [31:0] min_value;
    logic [4:0]         min_position;
    logic signed [31:0] max_value;
    logic [4:0]         max_position;

    modport source (output valid, output status, output count, output has_extremes,
                    output min_value, output min_position, output max_value,
                    output max_position, input ready);
    modport sink (input valid, input status, input count, input has_extremes,
                  input min_value, input min_position, input max_value,
                  input max_position, output ready);
endinterface

`default_nettype wire

/* src/bal_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module bal_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire bal_pkg::bal_stat_t stat,
    output bal_pkg::bal_cmd_t      cmd
);
    import bal_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.walk_init = 1'b1;
                unique case (stat.mode)
                    MODE_APPEND:
                    begin
                        cmd.status_we = 1'b1;
                        if (stat.full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                            cmd.status = ST_OK;
                        end
                        state_next = S_SCAN;
                    end
                    MODE_APPEND_UNIQUE:
                    begin
                        state_next = S_SEARCH;
                    end
                    MODE_REMOVE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.status_we = 1'b1;
                            cmd.status    = ST_EMPTY;
                            state_next    = S_SCAN;
                        end
                        else
                        begin
                            state_next = S_SEARCH;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        cmd.clear     = 1'b1;
                        cmd.status_we = 1'b1;
                        cmd.status    = ST_OK;
                        state_next    = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_SCAN;
                    end
                endcase
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (stat.hit)
                begin
                    if (stat.mode == MODE_APPEND_UNIQUE)
                    begin
                        cmd.status_we = 1'b1;
                        cmd.status    = ST_DUPLICATE;
                        cmd.walk_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        cmd.shift_init = 1'b1;
                        state_next     = S_SHIFT;
                    end
                end
                else if (stat.walk_done)
                begin
                    cmd.status_we = 1'b1;
                    cmd.walk_init = 1'b1;
                    state_next    = S_SCAN;
                    if (stat.mode == MODE_APPEND_UNIQUE)
                    begin
                        if (stat.full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                            cmd.status = ST_OK;
                        end
                    end
                    else
                    begin
                        cmd.status = ST_NOT_FOUND;
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.walk_done)
                begin
                    cmd.remove    = 1'b1;
                    cmd.status_we = 1'b1;
                    cmd.status    = ST_OK;
                    cmd.walk_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/bal_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module bal_datapath (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire bal_pkg::bal_cmd_t       cmd,
    output bal_pkg::bal_stat_t           stat,
    input  wire logic [1:0]              req_mode,
    input  wire logic signed [31:0]      req_value,
    input  wire logic                    rsp_ready,
    output logic                         rsp_valid,
    output logic [2:0]                   rsp_status,
    output logic [bal_pkg::COUNT_W-1:0]  rsp_count,
    output logic                         rsp_has_extremes,
    output logic signed [31:0]           rsp_min_value,
    output logic [bal_pkg::POS_W-1:0]    rsp_min_position,
    output logic signed [31:0]           rsp_max_value,
    output logic [bal_pkg::POS_W-1:0]    rsp_max_position
);
    import bal_pkg::*;

    logic [DATA_W-1:0] mem [CAPACITY];

    mode_t             mode_reg;
    logic [DATA_W-1:0] value_reg;
    status_t           status_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  ptr_reg;
    logic              rd_vld_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              first_reg;
    logic [DATA_W-1:0] min_reg;
    logic [IDX_W-1:0]  min_pos_reg;
    logic [DATA_W-1:0] max_reg;
    logic [IDX_W-1:0]  max_pos_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_has_reg;
    logic [DATA_W-1:0] out_min_reg;
    logic [IDX_W-1:0]  out_min_pos_reg;
    logic [DATA_W-1:0] out_max_reg;
    logic [IDX_W-1:0]  out_max_pos_reg;

    logic              issue;
    logic              hit;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              count_zero;

    always_comb
    begin
        issue      = (cmd.search || cmd.shift || cmd.scan) && (ptr_reg < count_reg);
        hit        = rd_vld_reg && (rdata_reg == value_reg);
        count_zero = (count_reg == '0);
        mem_we     = cmd.append || (cmd.shift && rd_vld_reg);
        if (cmd.append)
        begin
            mem_waddr = count_reg[IDX_W-1:0];
            mem_wdata = value_reg;
        end
        else
        begin
            mem_waddr = rd_idx_reg - IDX_W'(1);
            mem_wdata = rdata_reg;
        end
        stat.full      = (count_reg == CNT_W'(CAPACITY));
        stat.empty     = count_zero;
        stat.hit       = hit;
        stat.walk_done = !rd_vld_reg && (ptr_reg >= count_reg);
        stat.out_free  = !out_valid_reg || rsp_ready;
        stat.mode      = mode_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            rdata_reg <= mem[ptr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.append)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.remove)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            else if (cmd.clear)
            begin
                count_reg <= '0;
            end

            if (cmd.walk_init || cmd.shift_init)
            begin
                rd_vld_reg <= 1'b0;
            end
            else
            begin
                rd_vld_reg <= issue;
            end

            if (cmd.result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode_t'(req_mode);
            value_reg <= req_value;
        end
        if (cmd.status_we)
        begin
            status_reg <= cmd.status;
        end

        if (issue)
        begin
            rd_idx_reg <= ptr_reg[IDX_W-1:0];
        end
        if (cmd.walk_init)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.shift_init)
        begin
            ptr_reg <= CNT_W'(rd_idx_reg) + CNT_W'(1);
        end
        else if (issue)
        begin
            ptr_reg <= ptr_reg + CNT_W'(1);
        end

        if (cmd.walk_init)
        begin
            first_reg <= 1'b1;
        end
        else if (cmd.scan && rd_vld_reg)
        begin
            first_reg <= 1'b0;
        end

        if (cmd.scan && rd_vld_reg)
        begin
            if (first_reg)
            begin
                min_reg     <= rdata_reg;
                max_reg     <= rdata_reg;
                min_pos_reg <= rd_idx_reg;
                max_pos_reg <= rd_idx_reg;
            end
            else
            begin
                if ($signed(rdata_reg) < $signed(min_reg))
                begin
                    min_reg     <= rdata_reg;
                    min_pos_reg <= rd_idx_reg;
                end
                if ($signed(rdata_reg) > $signed(max_reg))
                begin
                    max_reg     <= rdata_reg;
                    max_pos_reg <= rd_idx_reg;
                end
            end
        end

        if (cmd.result)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= count_reg;
            out_has_reg    <= !count_zero;
            if (count_zero)
            begin
                out_min_reg     <= '0;
                out_min_pos_reg <= '0;
                out_max_reg     <= '0;
                out_max_pos_reg <= '0;
            end
            else
            begin
                out_min_reg     <= min_reg;
                out_min_pos_reg <= min_pos_reg;
                out_max_reg     <= max_reg;
                out_max_pos_reg <= max_pos_reg;
            end
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign rsp_status       = out_status_reg;
    assign rsp_count        = COUNT_W'(out_count_reg);
    assign rsp_has_extremes = out_has_reg;
    assign rsp_min_value    = $signed(out_min_reg);
    assign rsp_min_position = POS_W'(out_min_pos_reg);
    assign rsp_max_value    = $signed(out_max_reg);
    assign rsp_max_position = POS_W'(out_max_pos_reg);

endmodule

`default_nettype wire

/* src/bounded_array_list_engine.sv */
// Channel | Dir | Transaction payload
// --------+-----+-----------------------------------------------------------------
// req     | in  | mode, value
// rsp     | out | status, count, has_extremes, min_value/position, max_value/position
//
// One item runs through accept, dispatch, a search walk and a shift-down walk where its
// mode calls for them, and a min/max scan, each walk one entry per cycle through the
// single, registered read port of the entry memory, then the load of the output register.
// Reset empties the list; entry contents are not cleared.
// req is taken only while the engine is idle; a result waiting on rsp does not
// block the next request, which holds in its last step until rsp frees.
`timescale 1ns / 1ps
`default_nettype none

module bounded_array_list_engine (
    input  wire logic clk,
    input  wire logic rst_n,
    bal_in_if.sink    req,
    bal_out_if.source rsp
);
    import bal_pkg::*;

    bal_cmd_t  cmd;
    bal_stat_t stat;
    logic      req_ready;

    bal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bal_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .req_mode         (req.mode),
        .req_value        (req.value),
        .rsp_ready        (rsp.ready),
        .rsp_valid        (rsp.valid),
        .rsp_status       (rsp.status),
        .rsp_count        (rsp.count),
        .rsp_has_extremes (rsp.has_extremes),
        .rsp_min_value    (rsp.min_value),
        .rsp_min_position (rsp.min_position),
        .rsp_max_value    (rsp.max_value),
        .rsp_max_position (rsp.max_position)
    );

    assign req.ready = req_ready;

endmodule

`default_nettype wire

/* src/bal_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module bal_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire logic [5:0]         count,
    input wire logic               has_extremes,
    input wire logic signed [31:0] min_value,
    input wire logic [4:0]         min_position,
    input wire logic signed [31:0] max_value,
    input wire logic [4:0]         max_position
);
    import bal_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(count) && $stable(min_value))
        else $error("rsp transaction dropped or changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> count <= 6'(CAPACITY))
        else $error("count above capacity");

    a_has_extremes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> has_extremes == (count != 6'd0))
        else $error("has_extremes disagrees with count");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !has_extremes |-> min_value == 32'sd0 && max_value == 32'sd0
            && min_position == 5'd0 && max_position == 5'd0)
        else $error("empty list reports nonzero extremes");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && has_extremes |-> min_value <= max_value)
        else $error("min above max");

endmodule

bind bounded_array_list_engine bal_checker u_bal_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .count        (rsp.count),
    .has_extremes (rsp.has_extremes),
    .min_value    (rsp.min_value),
    .min_position (rsp.min_position),
    .max_value    (rsp.max_value),
    .max_position (rsp.max_position)
);

`default_nettype wire

/* tb/bounded_array_list_engine_tb.sv */
`timescale 1ns / 1ps

module bounded_array_list_engine_tb;

    import bal_pkg::*;

    typedef struct {
        mode_t              mode;
        logic signed [31:0] value;
    } list_op_t;

    typedef struct {
        status_t            status;
        logic [5:0]         count;
        logic               has_extremes;
        logic signed [31:0] min_value;
        logic [4:0]         min_position;
        logic signed [31:0] max_value;
        logic [4:0]         max_position;
    } list_summary_t;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_req;

    bal_in_if  req_if ();
    bal_out_if rsp_if ();

    bounded_array_list_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    list_op_t           pending_ops [$];
    list_summary_t      expected_summaries [$];
    logic signed [31:0] shadow_list [$];

    list_op_t next_op;
    int       ops_total;
    int       ops_accepted = 0;
    int       summaries_seen = 0;
    int       mismatches = 0;
    int       send_gap = 0;
    int       send_quiet = 0;
    int       recv_stall = 0;
    int       recv_quiet = 0;

    always #2 clk = ~clk;

    function automatic list_summary_t apply_op(mode_t mode, logic signed [31:0] value);
        list_summary_t s;
        int            hit;
        hit = -1;
        s.status = ST_OK;
        for (int i = 0; i < shadow_list.size(); i++)
        begin
            if (hit < 0 && shadow_list[i] == value)
                hit = i;
        end
        case (mode)
            MODE_APPEND, MODE_APPEND_UNIQUE:
            begin
                if (mode == MODE_APPEND_UNIQUE && hit >= 0)
                    s.status = ST_DUPLICATE;
                else if (shadow_list.size() >= CAPACITY)
                    s.status = ST_FULL;
                else
                    shadow_list.push_back(value);
            end
            MODE_REMOVE:
            begin
                if (shadow_list.size() == 0)
                    s.status = ST_EMPTY;
                else if (hit < 0)
                    s.status = ST_NOT_FOUND;
                else
                    shadow_list.delete(hit);
            end
            default:
                shadow_list.delete();
        endcase
        s.count        = 6'(shadow_list.size());
        s.has_extremes = (shadow_list.size() != 0);
        s.min_value    = 0;
        s.min_position = 0;
        s.max_value    = 0;
        s.max_position = 0;
        if (s.has_extremes)
        begin
            s.min_value = shadow_list[0];
            s.max_value = shadow_list[0];
            for (int i = 1; i < shadow_list.size(); i++)
            begin
                if (shadow_list[i] < s.min_value)
                begin
                    s.min_value    = shadow_list[i];
                    s.min_position = 5'(i);
                end
                if (shadow_list[i] > s.max_value)
                begin
                    s.max_value    = shadow_list[i];
                    s.max_position = 5'(i);
                end
            end
        end
        return s;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            flag_mismatch($sformatf("result %0d %s got %0d want %0d",
                                    summaries_seen, name, got, want));
    endtask

    task automatic check_summary();
        list_summary_t want;
        if (expected_summaries.size() == 0)
        begin
            flag_mismatch("result arrived with no transaction outstanding");
        end
        else
        begin
            want = expected_summaries.pop_front();
            check_field("status", rsp_if.status, want.status);
            check_field("count", rsp_if.count, want.count);
            check_field("has_extremes", rsp_if.has_extremes, want.has_extremes);
            check_field("min_value", rsp_if.min_value, want.min_value);
            check_field("min_position", rsp_if.min_position, want.min_position);
            check_field("max_value", rsp_if.max_value, want.max_value);
            check_field("max_position", rsp_if.max_position, want.max_position);
        end
    endtask

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        case (r)
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'hFFFFFFFF;
            3: return 32'h00000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(input mode_t mode, input logic signed [31:0] value);
        list_op_t op;
        op.mode  = mode;
        op.value = value;
        pending_ops.push_back(op);
    endtask

    task automatic build_directed();
        add_op(MODE_CLEAR, 32'h1234);
        add_op(MODE_REMOVE, 5);
        add_op(MODE_APPEND, 32'h7FFFFFFF);
        add_op(MODE_APPEND, 32'h80000000);
        add_op(MODE_APPEND, -1);
        add_op(MODE_APPEND, 0);
        add_op(MODE_APPEND_UNIQUE, -1);
        add_op(MODE_APPEND_UNIQUE, 12345);
        add_op(MODE_APPEND, 32'h7FFFFFFF);
        add_op(MODE_APPEND, 32'h80000000);
        add_op(MODE_REMOVE, 777);
        add_op(MODE_REMOVE, 32'h7FFFFFFF);
        add_op(MODE_REMOVE, 32'h80000000);
        add_op(MODE_REMOVE, -1);
        add_op(MODE_CLEAR, 0);
        add_op(MODE_CLEAR, -1);
        add_op(MODE_APPEND_UNIQUE, 42);
        add_op(MODE_REMOVE, 42);
        add_op(MODE_REMOVE, 42);
        add_op(MODE_APPEND, 32'h55555555);
        add_op(MODE_APPEND, 32'hAAAAAAAA);
        add_op(MODE_APPEND_UNIQUE, 32'hAAAAAAAA);
        add_op(MODE_CLEAR, 32'hFFFFFFFF);
    endtask

    task automatic build_random();
        logic signed [31:0] pool [8];
        logic signed [31:0] recent [$];
        logic signed [31:0] v;
        mode_t              m;
        int                 kind;
        int                 len;
        int                 r;
        int                 rv;
        int                 made;
        made = 0;
        while (made < 1200)
        begin
            kind = (made == 0) ? 0 : $urandom_range(0, 9);
            len  = (made == 0) ? 45 : $urandom_range(20, 50);
            foreach (pool[i])
            begin
                if (recent.size() > 0 && $urandom_range(0, 2) == 0)
                    pool[i] = recent[$urandom_range(0, recent.size() - 1)];
                else
                    pool[i] = rand_value();
            end
            for (int j = 0; j < len; j++)
            begin
                r = $urandom_range(0, 99);
                if (kind <= 3)
                    m = (r < 50) ? MODE_APPEND : (r < 92) ? MODE_APPEND_UNIQUE :
                        (r < 99 || made == 0) ? MODE_REMOVE : MODE_CLEAR;
                else if (kind <= 6)
                    m = (r < 75) ? MODE_REMOVE : (r < 88) ? MODE_APPEND :
                        (r < 98) ? MODE_APPEND_UNIQUE : MODE_CLEAR;
                else if (kind <= 8)
                    m = (r < 30) ? MODE_APPEND : (r < 60) ? MODE_APPEND_UNIQUE :
                        (r < 95) ? MODE_REMOVE : MODE_CLEAR;
                else
                    m = (r < 25) ? MODE_APPEND : (r < 50) ? MODE_APPEND_UNIQUE :
                        (r < 80) ? MODE_REMOVE : MODE_CLEAR;
                rv = $urandom_range(0, 99);
                if (m == MODE_REMOVE && rv < 65 && recent.size() > 0)
                    v = recent[$urandom_range(0, recent.size() - 1)];
                else if (rv < 85)
                    v = pool[$urandom_range(0, 7)];
                else
                    v = rand_value();
                add_op(m, v);
                if (m == MODE_APPEND || m == MODE_APPEND_UNIQUE)
                begin
                    recent.push_back(v);
                    if (recent.size() > 64)
                        void'(recent.pop_front());
                end
                made++;
            end
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                expected_summaries.push_back(apply_op(mode_t'(req_if.mode), req_if.value));
                ops_accepted++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    next_op = pending_ops.pop_front();
                    req_if.mode  <= next_op.mode;
                    req_if.value <= next_op.value;
                    req_if.valid <= 1'b1;
                    if (send_quiet > 0)
                    begin
                        send_quiet--;
                        send_gap = 0;
                    end
                    else
                    begin
                        send_gap = pick_idle();
                        if ($urandom_range(0, 49) == 0)
                            send_quiet = $urandom_range(20, 80);
                    end
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                check_summary();
                summaries_seen++;
                if (recv_quiet > 0)
                begin
                    recv_quiet--;
                    recv_stall = 0;
                end
                else
                begin
                    recv_stall = pick_idle();
                    if ($urandom_range(0, 49) == 0)
                        recv_quiet = $urandom_range(20, 80);
                end
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
            end
            rsp_if.ready <= !hold_req && (recv_stall == 0);
        end
    end

    // hold off the result side long enough to back up the request side
    initial
    begin
        hold_req = 1'b0;
        while (summaries_seen < 200)
            @(posedge clk);
        hold_req <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req <= 1'b0;
    end

    initial
    begin
        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.mode   = MODE_APPEND;
        req_if.value  = 0;
        rsp_if.ready  = 1'b0;
        build_directed();
        build_random();
        ops_total = pending_ops.size();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        while (ops_accepted < ops_total)
            @(posedge clk);
        while (expected_summaries.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
